// ===== hdl/hcpp_pkg.sv =====
// Shared types, constants and hex decode for the hex command packet parser.
package hcpp_pkg;

    localparam int unsigned ByteW     = 8;
    localparam int unsigned DigitW    = 4;
    localparam int unsigned CountW    = 8;
    localparam int unsigned MaskW     = 16;
    localparam int unsigned CfgIndexW = 8;
    localparam int unsigned OutDataW  = 40;

    // Register indexes on the configuration channel
    localparam logic [CfgIndexW-1:0] REG_HEADER_FIRST  = 8'd0;
    localparam logic [CfgIndexW-1:0] REG_HEADER_SECOND = 8'd1;
    localparam logic [CfgIndexW-1:0] REG_PING_LIMIT    = 8'd2;
    localparam logic [CfgIndexW-1:0] REG_REQUEST_MIN   = 8'd3;

    localparam logic [ByteW-1:0]  HEADER_FIRST_RST  = 8'h00;
    localparam logic [ByteW-1:0]  HEADER_SECOND_RST = 8'h00;
    localparam logic [DigitW-1:0] PING_LIMIT_RST    = 4'd1;
    localparam logic [DigitW-1:0] REQUEST_MIN_RST   = 4'd2;

    localparam logic [ByteW-1:0] ASCII_ZERO   = 8'h30;
    localparam logic [ByteW-1:0] ALPHA_OFFSET = 8'h27;

    typedef struct packed {
        logic [ByteW-1:0]  header_first;
        logic [ByteW-1:0]  header_second;
        logic [DigitW-1:0] ping_type_limit;
        logic [DigitW-1:0] request_type_min;
    } cfg_t;

    typedef struct packed {
        logic              withhold;
        logic              withhold_valid;
        logic [MaskW-1:0]  request_mask;
        logic [CountW-1:0] request_count;
        logic              request_commit;
        logic              stop_sending;
        logic [DigitW-1:0] cmd_argument;
        logic [DigitW-1:0] cmd_type;
        logic              cmd_valid;
    } result_t;

    // Lower-case hex digit; bytes 8'h57 to 8'h60 also decode to 0 to 9, and anything else reads as zero
    function automatic logic [DigitW-1:0] hex_digit(input logic [ByteW-1:0] b);
        logic [ByteW-1:0] v;
        v = b - ASCII_ZERO;
        if (v > 8'd9) begin
            v = v - ALPHA_OFFSET;
        end
        if (v > 8'd15) begin
            v = '0;
        end
        return v[DigitW-1:0];
    endfunction

endpackage

// ===== hdl/hcpp_cfg.sv =====
// Configuration register bank.
module hcpp_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hcpp_pkg::CfgIndexW-1:0]  cfg_index,
    input  logic [hcpp_pkg::ByteW-1:0]      cfg_data,
    output hcpp_pkg::cfg_t                  cfg
);

    hcpp_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_first     <= hcpp_pkg::HEADER_FIRST_RST;
            cfg_reg.header_second    <= hcpp_pkg::HEADER_SECOND_RST;
            cfg_reg.ping_type_limit  <= hcpp_pkg::PING_LIMIT_RST;
            cfg_reg.request_type_min <= hcpp_pkg::REQUEST_MIN_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                hcpp_pkg::REG_HEADER_FIRST:  cfg_reg.header_first  <= cfg_data;
                hcpp_pkg::REG_HEADER_SECOND: cfg_reg.header_second <= cfg_data;
                hcpp_pkg::REG_PING_LIMIT:
                    cfg_reg.ping_type_limit <= cfg_data[hcpp_pkg::DigitW-1:0];
                hcpp_pkg::REG_REQUEST_MIN:
                    cfg_reg.request_type_min <= cfg_data[hcpp_pkg::DigitW-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== hdl/hcpp_core.sv =====
// Input byte register and packet parse state machine.
module hcpp_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [hcpp_pkg::ByteW-1:0]  in_byte,
    input  hcpp_pkg::cfg_t              cfg,
    input  logic                        out_free,
    output logic                        res_valid,
    output hcpp_pkg::result_t           res
);

    typedef enum logic [3:0] {
        PH_HDR1  = 4'd0,
        PH_HDR2  = 4'd1,
        PH_TYPE  = 4'd2,
        PH_ARG   = 4'd3,
        PH_COUNT = 4'd4,
        PH_MASK0 = 4'd5,
        PH_MASK1 = 4'd6,
        PH_MASK2 = 4'd7,
        PH_MASK3 = 4'd8
    } phase_t;

    phase_t                         phase_reg, phase_next;
    logic                           in_valid_reg;
    logic [hcpp_pkg::ByteW-1:0]     in_byte_reg;
    logic [hcpp_pkg::DigitW-1:0]    type_reg, type_next;
    logic [hcpp_pkg::DigitW-1:0]    arg_reg, arg_next;
    logic [hcpp_pkg::CountW-1:0]    count_reg, count_next;
    logic [hcpp_pkg::MaskW-1:0]     mask_reg, mask_next;
    logic [hcpp_pkg::DigitW-1:0]    digit;
    logic                           advance;

    assign advance   = in_valid_reg && out_free;
    assign in_ready  = !in_valid_reg || advance;
    assign res_valid = advance;
    assign digit     = hcpp_pkg::hex_digit(in_byte_reg);

    always_comb begin
        phase_next = phase_reg;
        type_next  = type_reg;
        arg_next   = arg_reg;
        count_next = count_reg;
        mask_next  = mask_reg;
        res        = '0;
        unique case (phase_reg)
            PH_HDR1: begin
                if (in_byte_reg == cfg.header_first) phase_next = PH_HDR2;
            end
            PH_HDR2: begin
                if (in_byte_reg == cfg.header_second) phase_next = PH_TYPE;
            end
            PH_TYPE: begin
                type_next  = digit;
                phase_next = PH_ARG;
            end
            PH_ARG: begin
                arg_next = digit;
                // ping test wins where the two ranges overlap
                if (type_reg <= cfg.ping_type_limit) begin
                    res.cmd_valid    = 1'b1;
                    res.cmd_type     = type_reg;
                    res.cmd_argument = digit;
                    res.stop_sending = 1'b1;
                    phase_next       = PH_HDR1;
                end else if (type_reg >= cfg.request_type_min) begin
                    count_next = {digit, {hcpp_pkg::DigitW{1'b0}}};
                    phase_next = PH_COUNT;
                end else begin
                    phase_next = PH_HDR1;
                end
            end
            PH_COUNT: begin
                count_next         = count_reg + {{hcpp_pkg::DigitW{1'b0}}, digit};
                res.withhold_valid = 1'b1;
                if (count_next != '0) begin
                    phase_next = PH_MASK0;
                end else begin
                    res.withhold = 1'b1;
                    phase_next   = PH_HDR1;
                end
            end
            PH_MASK0: begin
                mask_next  = {digit, 12'h000};
                phase_next = PH_MASK1;
            end
            PH_MASK1: begin
                mask_next  = mask_reg | {4'h0, digit, 8'h00};
                phase_next = PH_MASK2;
            end
            PH_MASK2: begin
                mask_next  = mask_reg | {8'h00, digit, 4'h0};
                phase_next = PH_MASK3;
            end
            PH_MASK3: begin
                mask_next          = mask_reg | {12'h000, digit};
                res.cmd_valid      = 1'b1;
                res.cmd_type       = type_reg;
                res.cmd_argument   = arg_reg;
                res.request_commit = 1'b1;
                res.request_count  = count_reg;
                res.request_mask   = mask_next;
                phase_next         = PH_HDR1;
            end
            default: phase_next = PH_HDR1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_HDR1;
            type_reg     <= '0;
            arg_reg      <= '0;
            count_reg    <= '0;
            mask_reg     <= '0;
        end else begin
            if (in_valid && in_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                phase_reg <= phase_next;
                type_reg  <= type_next;
                arg_reg   <= arg_next;
                count_reg <= count_next;
                mask_reg  <= mask_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            in_byte_reg <= in_byte;
        end
    end

endmodule

// ===== hdl/hex_command_packet_parser.sv =====
// Top level of the hex command packet parser: config bank, parser and result register.
// Takes one received byte per cycle unless m_tready stalls the result register, and
// returns exactly one result per byte, in order. A byte goes through the input register,
// the parse logic and the result register before its result is offered on m_tvalid;
// with m_tready held high the block sustains one byte every cycle. Configuration should
// only be written while the parser has no byte in flight.
module hex_command_packet_parser (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hcpp_pkg::ByteW-1:0]      s_tdata,   // [7:0] rx_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] cmd_valid, [4:1] cmd_type, [8:5] cmd_argument, [9] stop_sending,
    // [10] request_commit, [18:11] request_count, [34:19] request_mask,
    // [35] withhold_valid, [36] withhold, [39:37] zero
    output logic [hcpp_pkg::OutDataW-1:0]   m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hcpp_pkg::CfgIndexW-1:0]  cfg_index,
    input  logic [hcpp_pkg::ByteW-1:0]      cfg_data
);

    localparam int unsigned ResW = $bits(hcpp_pkg::result_t);

    hcpp_pkg::cfg_t     cfg;
    hcpp_pkg::result_t  res;
    logic               res_valid;
    logic               m_valid_reg;
    hcpp_pkg::result_t  m_res_reg;
    logic               out_free;

    assign out_free = !m_valid_reg || m_tready;

    hcpp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hcpp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .cfg       (cfg),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(hcpp_pkg::OutDataW - ResW){1'b0}}, m_res_reg};

endmodule
